// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the per-flow statistics block.
// Included by the top level, which checks its own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check that a property holds at every clock edge outside reset
`define PFTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// check that an event is later followed by another one
`define PFTS_ASSERT_NEXT2(label, clk, rst, trig, resp, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> ##1 (resp)) \
      else $error(msg);
`else
`define PFTS_ASSERT(label, clk, rst, prop, msg)
`define PFTS_ASSERT_NEXT2(label, clk, rst, trig, resp, msg)
`endif
`endif

// File: rtl/core/pfts_pkg.sv
// Types and constants of the per-flow traffic statistics block.
// No dependencies; used by the divider, the top level and the testbench.
package pfts_pkg;

   // item kinds
   localparam logic [2:0] KIND_TX         = 3'd0;
   localparam logic [2:0] KIND_RX         = 3'd1;
   localparam logic [2:0] KIND_READ_INTV  = 3'd2;
   localparam logic [2:0] KIND_READ_TOTAL = 3'd3;
   localparam logic [2:0] KIND_CLEAR_ALL  = 3'd4;

   localparam int          SCALE_W    = 20;
   localparam logic [19:0] RATE_SCALE = 20'd1000000;
   localparam logic [19:0] LOSS_SCALE = 20'd10000;
   localparam logic [19:0] UNIT_SCALE = 20'd1;
   localparam logic [13:0] LOSS_MAX   = 14'd10000;
   localparam logic [63:0] ALL_ONES64 = {64{1'b1}};

   typedef struct packed {
      logic [63:0] tx_pkts;
      logic [63:0] tx_octets;
      logic [63:0] rx_pkts;
      logic [63:0] rx_octets;
      logic [63:0] lost;
      logic [63:0] lat_sum;
      logic [63:0] lat_min;
      logic [63:0] lat_max;
   } stats_set_type;

   typedef struct packed {
      logic [31:0] last_seq;
      logic        seq_seen;
      logic [63:0] last_transit;
      logic        transit_seen;
      logic [63:0] jitter;
   } flow_type;

   typedef struct packed {
      stats_set_type set;
      flow_type      flow;
   } total_entry_type;

   localparam stats_set_type SET_RESET = '{
      tx_pkts: 64'd0, tx_octets: 64'd0, rx_pkts: 64'd0, rx_octets: 64'd0,
      lost: 64'd0, lat_sum: 64'd0, lat_min: ALL_ONES64, lat_max: 64'd0};

   localparam flow_type FLOW_RESET = '{
      last_seq: 32'd0, seq_seen: 1'b0, last_transit: 64'd0,
      transit_seen: 1'b0, jitter: 64'd0};

   localparam total_entry_type ENTRY_RESET = '{set: SET_RESET, flow: FLOW_RESET};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_UPD,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_OUT
   } ctl_state_type;

   typedef enum logic [2:0] {
      DIV_IDLE,
      DIV_MUL,
      DIV_SUM,
      DIV_ITER,
      DIV_DONE
   } div_state_type;

   // request to the divider: floor(a * k / d), saturated
   typedef struct packed {
      logic               start;
      logic [63:0]        a;
      logic [SCALE_W-1:0] k;
      logic [63:0]        d;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] q;
   } div_rsp_type;

endpackage

// File: rtl/core/pfts_if.sv
// Valid/ready channels of the per-flow traffic statistics block.
// Request and response words; no dependencies beyond plain logic.
interface pfts_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [2:0]  proto;
   logic [15:0] byte_count;
   logic [31:0] seq_num;
   logic [63:0] send_time;
   logic [63:0] recv_time;
   logic [63:0] elapsed_time;

   modport source (output valid, kind, proto, byte_count, seq_num, send_time,
                   recv_time, elapsed_time, input ready);
   modport sink (input valid, kind, proto, byte_count, seq_num, send_time,
                 recv_time, elapsed_time, output ready);
endinterface

interface pfts_rsp_if;
   logic        valid;
   logic        ready;
   logic        active;
   logic [63:0] tx_count;
   logic [63:0] rx_count;
   logic [63:0] lost_count;
   logic [13:0] loss_hundredths;
   logic [63:0] packets_per_sec;
   logic [63:0] bytes_per_sec;
   logic [63:0] latency_avg;
   logic [63:0] latency_min;
   logic [63:0] latency_max;
   logic [63:0] jitter;

   modport source (output valid, active, tx_count, rx_count, lost_count,
                   loss_hundredths, packets_per_sec, bytes_per_sec, latency_avg,
                   latency_min, latency_max, jitter, input ready);
   modport sink (input valid, active, tx_count, rx_count, lost_count,
                 loss_hundredths, packets_per_sec, bytes_per_sec, latency_avg,
                 latency_min, latency_max, jitter, output ready);
endinterface

// File: rtl/core/pfts_div.sv
// Shared multiply-divide unit: floor(a * k / d) with saturation, one quotient
// bit per cycle. Depends on pfts_pkg.
module pfts_div (
   input  logic                 clock,
   input  logic                 reset,
   input  pfts_pkg::div_req_type div_req,
   output pfts_pkg::div_rsp_type div_rsp
);
   import pfts_pkg::*;

   div_state_type      state_ff, state_in;
   logic [63:0]        a_ff;
   logic [SCALE_W-1:0] k_ff;
   logic [63:0]        d_ff;
   logic [51:0]        plo_ff;
   logic [51:0]        phi_ff;
   logic [63:0]        lo_ff;
   logic [63:0]        rem_ff;
   logic [63:0]        q_ff;
   logic [5:0]         cnt_ff;
   logic [127:0]       prod;
   logic [64:0]        trial;
   logic               fit;
   logic               sat;

   // assemble the exact product from the two partial products
   assign prod  = {76'd0, plo_ff} + ({76'd0, phi_ff} << 32);
   assign sat   = prod[127:64] >= d_ff;
   assign trial = {rem_ff, lo_ff[63]};
   assign fit   = trial >= {1'b0, d_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DIV_IDLE: if (div_req.start) state_in = DIV_MUL;
         DIV_MUL:  state_in = DIV_SUM;
         DIV_SUM:  state_in = sat ? DIV_DONE : DIV_ITER;
         DIV_ITER: if (cnt_ff == 6'd63) state_in = DIV_DONE;
         DIV_DONE: state_in = DIV_IDLE;
         default:  state_in = DIV_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      div_rsp.done = (state_ff == DIV_DONE);
      div_rsp.q    = q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath: capture operands, multiply, then shift-subtract
   always_ff @(posedge clock) begin
      unique case (state_ff)
         DIV_IDLE: begin
            a_ff <= div_req.a;
            k_ff <= div_req.k;
            d_ff <= div_req.d;
         end
         DIV_MUL: begin
            plo_ff <= 52'(a_ff[31:0]) * 52'(k_ff);
            phi_ff <= 52'(a_ff[63:32]) * 52'(k_ff);
         end
         DIV_SUM: begin
            q_ff   <= sat ? ALL_ONES64 : 64'd0;
            rem_ff <= prod[127:64];
            lo_ff  <= prod[63:0];
            cnt_ff <= 6'd0;
         end
         DIV_ITER: begin
            rem_ff <= fit ? 64'(trial - {1'b0, d_ff}) : trial[63:0];
            q_ff   <= {q_ff[62:0], fit};
            lo_ff  <= {lo_ff[62:0], 1'b0};
            cnt_ff <= cnt_ff + 6'd1;
         end
         DIV_DONE: begin
            q_ff <= q_ff;
         end
         default: begin
            q_ff <= q_ff;
         end
      endcase
   end
endmodule

// File: rtl/core/per_flow_traffic_stats_unit.sv
// Per-flow traffic statistics: one entry per protocol with totals, interval
// counts, loss from sequence gaps, latency sum/min/max and smoothed jitter.
// Channels: req (valid/ready) carries records and reads, rsp (valid/ready)
// returns one word for each read of an in-range entry; records, clears and
// out-of-range or unknown kinds return nothing.
// Throughput: one word at a time. A tx or rx record passes through accept,
// entry read from the state memories and write-back; a clear-all is taken
// at accept. A read runs four multiply-divides one after another on the
// shared divider (each a multiply, then one quotient bit per cycle); a
// divide whose divisor is zero is skipped.
// Reset: synchronous; per-entry valid bits make every entry read as zeros
// (latency minimum as all ones) at once, with no clearing pass.
// Stall: a finished read result waits in the output register; the next word
// is accepted meanwhile, and a second result waits until the first is taken.
`include "assert_macros.svh"
module per_flow_traffic_stats_unit #(
   parameter int NUM_PROTOCOLS = 8
) (
   input logic        clock,
   input logic        reset,
   pfts_req_if.sink   req,
   pfts_rsp_if.source rsp
);
   import pfts_pkg::*;

   localparam int IDX_W = (NUM_PROTOCOLS > 1) ? $clog2(NUM_PROTOCOLS) : 1;

   ctl_state_type state_ff, state_in;

   // item held while it is worked on
   logic [2:0]       kind_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [15:0]      len_ff;
   logic [31:0]      seq_ff;
   logic [63:0]      transit_ff;
   logic [63:0]      elapsed_ff;

   // state memories and per-entry valid bits
   total_entry_type mem_total [NUM_PROTOCOLS];
   stats_set_type   mem_intv  [NUM_PROTOCOLS];
   total_entry_type rd_total_ff;
   stats_set_type   rd_intv_ff;
   logic [NUM_PROTOCOLS-1:0] total_vld_ff;
   logic [NUM_PROTOCOLS-1:0] intv_vld_ff;
   logic [IDX_W-1:0] rd_idx;

   // working copy of the entry
   stats_set_type tot_ff;
   stats_set_type intv_ff;
   flow_type      flow_ff;
   logic [63:0]   lat_ff;
   logic [63:0]   d_ff;

   // read path
   stats_set_type sel_ff;
   logic [63:0]   jit_ff;
   logic [63:0]   expected_ff;
   logic [1:0]    op_ff;
   logic [63:0]   pps_ff;
   logic [63:0]   bps_ff;
   logic [63:0]   avg_ff;
   logic [13:0]   loss_ff;

   logic rsp_valid_ff;

   logic          accept;
   logic          in_range;
   logic          is_work;
   logic          is_update;
   logic          wr_en;
   logic          rsp_load;
   logic          div_skip;
   logic          rec_accept;
   logic          loss_ok;
   logic          lat_ok;
   div_req_type   div_req;
   div_rsp_type   div_rsp;

   total_entry_type cur_total;
   stats_set_type   cur_intv;
   stats_set_type   cur_sel;
   logic [63:0]     cur_diff;
   logic [63:0]     div_val;
   logic [13:0]     loss_val;

   stats_set_type new_tot;
   stats_set_type new_intv;
   flow_type      new_flow;
   logic [31:0]   exp_seq;
   logic [63:0]   gap;
   logic [63:0]   jx;
   logic [63:0]   jm;

   // add one record to a statistics set
   function automatic stats_set_type upd_set(stats_set_type s, logic rx,
                                             logic [15:0] len, logic [63:0] lat,
                                             logic [63:0] gp);
      stats_set_type r;
      r = s;
      if (rx) begin
         r.rx_pkts   = s.rx_pkts + 64'd1;
         r.rx_octets = s.rx_octets + {48'd0, len};
         r.lost      = s.lost + gp;
         r.lat_sum   = s.lat_sum + lat;
         r.lat_min   = (lat < s.lat_min) ? lat : s.lat_min;
         r.lat_max   = (lat > s.lat_max) ? lat : s.lat_max;
      end else begin
         r.tx_pkts   = s.tx_pkts + 64'd1;
         r.tx_octets = s.tx_octets + {48'd0, len};
      end
      return r;
   endfunction

   assign accept    = req.valid && req.ready;
   assign in_range  = int'(req.proto) < NUM_PROTOCOLS;
   assign is_work   = (req.kind == KIND_TX) || (req.kind == KIND_RX) ||
                      (req.kind == KIND_READ_INTV) || (req.kind == KIND_READ_TOTAL);
   assign is_update = (kind_ff == KIND_TX) || (kind_ff == KIND_RX);
   assign rd_idx    = IDX_W'(req.proto);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept && in_range && is_work) state_in = ST_LOOK;
         ST_LOOK: state_in = is_update ? ST_UPD : ST_DIV_GO;
         ST_UPD:  state_in = ST_IDLE;
         ST_DIV_GO: begin
            if (!div_skip) state_in = ST_DIV_WAIT;
            else if (op_ff == 2'd3) state_in = ST_OUT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) state_in = (op_ff == 2'd3) ? ST_OUT : ST_DIV_GO;
         end
         ST_OUT: if (!rsp_valid_ff || rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req.ready = (state_ff == ST_IDLE);
      wr_en     = (state_ff == ST_UPD);
      rsp_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold the accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= req.kind;
         idx_ff     <= rd_idx;
         len_ff     <= req.byte_count;
         seq_ff     <= req.seq_num;
         transit_ff <= req.recv_time - req.send_time;
         elapsed_ff <= req.elapsed_time;
      end
   end

   // state memories: read at accept, write back after the update
   always_ff @(posedge clock) begin
      rd_total_ff <= mem_total[rd_idx];
      rd_intv_ff  <= mem_intv[rd_idx];
      if (wr_en) begin
         mem_total[idx_ff] <= '{set: new_tot, flow: new_flow};
         mem_intv[idx_ff]  <= new_intv;
      end
   end

   // valid bits: an invalid entry reads as its reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         total_vld_ff <= '0;
         intv_vld_ff  <= '0;
      end else begin
         if (accept && req.kind == KIND_CLEAR_ALL) begin
            intv_vld_ff <= '0;
         end
         if (state_ff == ST_LOOK && kind_ff == KIND_READ_INTV) begin
            intv_vld_ff[idx_ff] <= 1'b0;
         end
         if (wr_en) begin
            total_vld_ff[idx_ff] <= 1'b1;
            intv_vld_ff[idx_ff]  <= 1'b1;
         end
      end
   end

   // entry as seen after the valid bits
   always_comb begin
      cur_total = total_vld_ff[idx_ff] ? rd_total_ff : ENTRY_RESET;
      cur_intv  = intv_vld_ff[idx_ff] ? rd_intv_ff : SET_RESET;
      cur_sel   = (kind_ff == KIND_READ_INTV) ? cur_intv : cur_total.set;
      cur_diff  = transit_ff - cur_total.flow.last_transit;
   end

   // capture the entry, latency and transit difference
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOOK) begin
         tot_ff      <= cur_total.set;
         flow_ff     <= cur_total.flow;
         intv_ff     <= cur_intv;
         lat_ff      <= transit_ff[63] ? (64'd0 - transit_ff) : transit_ff;
         d_ff        <= cur_diff[63] ? (64'd0 - cur_diff) : cur_diff;
         sel_ff      <= cur_sel;
         jit_ff      <= cur_total.flow.jitter;
         expected_ff <= cur_sel.rx_pkts + cur_sel.lost;
      end
   end

   // record update: counters, loss gap, latency and jitter
   always_comb begin
      exp_seq  = flow_ff.last_seq + 32'd1;
      gap      = (flow_ff.seq_seen && seq_ff > exp_seq) ? {32'd0, seq_ff - exp_seq} : 64'd0;
      new_tot  = upd_set(tot_ff, kind_ff == KIND_RX, len_ff, lat_ff, gap);
      new_intv = upd_set(intv_ff, kind_ff == KIND_RX, len_ff, lat_ff, gap);
      jx       = d_ff - flow_ff.jitter;
      jm       = flow_ff.jitter - d_ff;
      new_flow = flow_ff;
      if (kind_ff == KIND_RX) begin
         new_flow.last_seq     = seq_ff;
         new_flow.seq_seen     = 1'b1;
         new_flow.last_transit = transit_ff;
         new_flow.transit_seen = 1'b1;
         if (flow_ff.transit_seen) begin
            if (d_ff >= flow_ff.jitter) begin
               new_flow.jitter = flow_ff.jitter + (jx >> 4) +
                                 {63'd0, jx[3:0] >= 4'd8};
            end else begin
               new_flow.jitter = flow_ff.jitter - (jm >> 4) -
                                 {63'd0, jm[3:0] >= 4'd9};
            end
         end
      end
   end

   // select the divide for the current step and start it unless skipped
   always_comb begin
      div_req.a = sel_ff.lost;
      div_req.k = LOSS_SCALE;
      div_req.d = expected_ff;
      div_skip  = 1'b0;
      unique case (op_ff)
         2'd0: begin
            div_req.a = (sel_ff.rx_pkts != 64'd0) ? sel_ff.rx_pkts : sel_ff.tx_pkts;
            div_req.k = RATE_SCALE;
            div_req.d = elapsed_ff;
            div_skip  = (elapsed_ff == 64'd0);
         end
         2'd1: begin
            div_req.a = (sel_ff.rx_pkts != 64'd0) ? sel_ff.rx_octets : sel_ff.tx_octets;
            div_req.k = RATE_SCALE;
            div_req.d = elapsed_ff;
            div_skip  = (elapsed_ff == 64'd0);
         end
         2'd2: begin
            div_req.a = sel_ff.lat_sum;
            div_req.k = UNIT_SCALE;
            div_req.d = sel_ff.rx_pkts;
            div_skip  = (sel_ff.rx_pkts == 64'd0);
         end
         2'd3: begin
            div_req.a = sel_ff.lost;
            div_req.k = LOSS_SCALE;
            div_req.d = expected_ff;
            div_skip  = (expected_ff == 64'd0);
         end
         default: div_skip = 1'b1;
      endcase
      div_req.start = (state_ff == ST_DIV_GO) && !div_skip;
   end

   assign div_val  = (state_ff == ST_DIV_GO) ? 64'd0 : div_rsp.q;
   assign loss_val = (div_val > {50'd0, LOSS_MAX}) ? LOSS_MAX : div_val[13:0];

   // collect quotients, advance through the four divides
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOOK) begin
         op_ff <= 2'd0;
      end else if ((state_ff == ST_DIV_GO && div_skip) ||
                   (state_ff == ST_DIV_WAIT && div_rsp.done)) begin
         op_ff <= op_ff + 2'd1;
         unique case (op_ff)
            2'd0: pps_ff  <= div_val;
            2'd1: bps_ff  <= div_val;
            2'd2: avg_ff  <= div_val;
            2'd3: loss_ff <= loss_val;
            default: loss_ff <= loss_val;
         endcase
      end
   end

   pfts_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp.active          <= (sel_ff.tx_pkts != 64'd0) || (sel_ff.rx_pkts != 64'd0);
         rsp.tx_count        <= sel_ff.tx_pkts;
         rsp.rx_count        <= sel_ff.rx_pkts;
         rsp.lost_count      <= sel_ff.lost;
         rsp.loss_hundredths <= loss_ff;
         rsp.packets_per_sec <= pps_ff;
         rsp.bytes_per_sec   <= bps_ff;
         rsp.latency_avg     <= avg_ff;
         rsp.latency_min     <= (sel_ff.lat_min == ALL_ONES64) ? 64'd0 : sel_ff.lat_min;
         rsp.latency_max     <= sel_ff.lat_max;
         rsp.jitter          <= jit_ff;
      end
   end

   assign rsp.valid = rsp_valid_ff;

   // terms checked below
   assign rec_accept = accept && in_range && (req.kind == KIND_TX || req.kind == KIND_RX);
   assign loss_ok    = rsp.loss_hundredths <= LOSS_MAX;
   assign lat_ok     = rsp.latency_min <= rsp.latency_max;

   `PFTS_ASSERT(a_loss_bound, clock, reset, !rsp.valid || loss_ok, "loss above 10000")
   `PFTS_ASSERT(a_lat_order, clock, reset, !rsp.valid || lat_ok, "latency min above max")
   `PFTS_ASSERT(a_div_done, clock, reset, !div_rsp.done || state_ff == ST_DIV_WAIT, "done early")
   `PFTS_ASSERT_NEXT2(a_rec_write, clock, reset, rec_accept, wr_en, "record not written back")
endmodule

// File: tb/tb_per_flow_traffic_stats_unit.sv
// Self-checking regression for per_flow_traffic_stats_unit: directed and random
// record/read/clear words, with an in-bench stats predictor and response scoreboard.
// Depends on pfts_pkg, pfts_req_if / pfts_rsp_if and the unit itself.
`timescale 1ns / 100ps
module tb_per_flow_traffic_stats_unit;
   import pfts_pkg::*;

   localparam int          NPROTO          = 8;
   localparam logic [2:0]  KIND_UNUSED_MIN = 3'd5;
   localparam logic [2:0]  KIND_UNUSED_MAX = 3'd7;
   localparam int          CYCLE_LIMIT     = 1000000;
   localparam int          RANDOM_WORDS    = 860;
   localparam int          HOLDOFF_CYCLES  = 1500;
   localparam int          DRAIN_CYCLES    = 400;
   localparam logic [63:0] MAX64           = {64{1'b1}};

   typedef struct {
      logic        active;
      logic [63:0] tx_count;
      logic [63:0] rx_count;
      logic [63:0] lost_count;
      logic [13:0] loss_hundredths;
      logic [63:0] packets_per_sec;
      logic [63:0] bytes_per_sec;
      logic [63:0] latency_avg;
      logic [63:0] latency_min;
      logic [63:0] latency_max;
      logic [63:0] jitter;
   } stats_word_type;

   logic clock;
   logic reset;

   pfts_req_if req_ch ();
   pfts_rsp_if rsp_ch ();

   per_flow_traffic_stats_unit #(.NUM_PROTOCOLS(NPROTO)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   // predicted entry contents
   stats_set_type  total_set [NPROTO];
   stats_set_type  intv_set  [NPROTO];
   flow_type       flow_state[NPROTO];
   stats_word_type pending_stats[$];

   int  fail_count;
   int  cycle_count;
   logic hold_rsp;
   logic [31:0] gen_seq [NPROTO];
   logic [63:0] gen_time[NPROTO];

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("per_flow_traffic_stats_unit regression: fail");
         $finish;
      end
   end

   // receiver stall pattern, with a long hold when asked
   always @(posedge clock) begin : rsp_stall
      int roll;
      roll = $urandom_range(0, 99);
      if (reset || hold_rsp)
         rsp_ch.ready <= 1'b0;
      else if ((cycle_count / 700) % 3 == 0)
         rsp_ch.ready <= 1'b1;
      else if ((cycle_count / 700) % 3 == 1)
         rsp_ch.ready <= (roll < 50);
      else
         rsp_ch.ready <= (roll < 10);
   end

   // floor(a * k / d) with exact product, saturated; d nonzero
   function automatic logic [63:0] scaled_quotient(logic [63:0] a, logic [63:0] k,
                                                   logic [63:0] d);
      logic [127:0] prod;
      logic [127:0] quo;
      prod = {64'd0, a} * {64'd0, k};
      if (prod[127:64] >= d) return MAX64;
      quo = prod / {64'd0, d};
      return quo[63:0];
   endfunction

   task automatic clear_entry_interval(int p);
      intv_set[p] = SET_RESET;
   endtask

   task automatic clear_predictor();
      for (int p = 0; p < NPROTO; p++) begin
         total_set[p]  = SET_RESET;
         intv_set[p]   = SET_RESET;
         flow_state[p] = FLOW_RESET;
      end
   endtask

   // fold one rx packet into a set
   function automatic stats_set_type add_rx(stats_set_type s, logic [15:0] bc,
                                            logic [63:0] gap, logic [63:0] lat);
      s.rx_pkts   = s.rx_pkts + 64'd1;
      s.rx_octets = s.rx_octets + {48'd0, bc};
      s.lost      = s.lost + gap;
      s.lat_sum   = s.lat_sum + lat;
      if (lat < s.lat_min) s.lat_min = lat;
      if (lat > s.lat_max) s.lat_max = lat;
      return s;
   endfunction

   // update the predicted entries for one accepted word, queue any response
   task automatic predict_stats(logic [2:0] kind, logic [2:0] proto, logic [15:0] bc,
                                logic [31:0] seq, logic [63:0] st, logic [63:0] rt,
                                logic [63:0] el);
      int p;
      logic [63:0] transit, lat, gap, dd, dmag, jit, sum;
      logic [31:0] next_seq;
      logic signed [65:0] step;
      stats_set_type s;
      stats_word_type w;
      p = int'(proto);
      gap = 64'd0;
      if (kind == KIND_CLEAR_ALL) begin
         for (int i = 0; i < NPROTO; i++) clear_entry_interval(i);
      end else if (kind == KIND_TX) begin
         total_set[p].tx_pkts   += 64'd1;
         total_set[p].tx_octets += {48'd0, bc};
         intv_set[p].tx_pkts    += 64'd1;
         intv_set[p].tx_octets  += {48'd0, bc};
      end else if (kind == KIND_RX) begin
         transit = rt - st;
         lat = transit[63] ? -transit : transit;
         next_seq = flow_state[p].last_seq + 32'd1;
         if (flow_state[p].seq_seen && seq > next_seq) gap = {32'd0, seq - next_seq};
         flow_state[p].last_seq = seq;
         flow_state[p].seq_seen = 1'b1;
         total_set[p] = add_rx(total_set[p], bc, gap, lat);
         intv_set[p]  = add_rx(intv_set[p], bc, gap, lat);
         if (flow_state[p].transit_seen) begin
            dd   = transit - flow_state[p].last_transit;
            dmag = dd[63] ? -dd : dd;
            jit  = flow_state[p].jitter;
            step = ($signed({2'b00, dmag}) - $signed({2'b00, jit}) + 66'sd8) >>> 4;
            flow_state[p].jitter = jit + step[63:0];
         end
         flow_state[p].last_transit = transit;
         flow_state[p].transit_seen = 1'b1;
      end else if (kind == KIND_READ_INTV || kind == KIND_READ_TOTAL) begin
         s = (kind == KIND_READ_INTV) ? intv_set[p] : total_set[p];
         w.active     = (s.tx_pkts != 0 || s.rx_pkts != 0);
         w.tx_count   = s.tx_pkts;
         w.rx_count   = s.rx_pkts;
         w.lost_count = s.lost;
         w.packets_per_sec = 64'd0;
         w.bytes_per_sec   = 64'd0;
         if (el != 0) begin
            w.packets_per_sec = scaled_quotient(s.rx_pkts != 0 ? s.rx_pkts : s.tx_pkts,
                                                64'd1000000, el);
            w.bytes_per_sec   = scaled_quotient(s.rx_pkts != 0 ? s.rx_octets : s.tx_octets,
                                                64'd1000000, el);
         end
         w.latency_avg = (s.rx_pkts != 0) ? s.lat_sum / s.rx_pkts : 64'd0;
         sum = s.rx_pkts + s.lost;
         w.loss_hundredths = 14'd0;
         if (sum != 0) begin
            jit = scaled_quotient(s.lost, 64'd10000, sum);
            if (jit > 64'd10000) jit = 64'd10000;
            w.loss_hundredths = jit[13:0];
         end
         w.latency_min = (s.lat_min == MAX64) ? 64'd0 : s.lat_min;
         w.latency_max = s.lat_max;
         w.jitter      = flow_state[p].jitter;
         pending_stats.push_back(w);
         if (kind == KIND_READ_INTV) clear_entry_interval(p);
      end
   endtask

   // drive one word and hold it until accepted; call at a rising edge
   task automatic send_word(logic [2:0] kind, logic [2:0] proto, logic [15:0] bc,
                            logic [31:0] seq, logic [63:0] st, logic [63:0] rt,
                            logic [63:0] el);
      req_ch.valid        <= 1'b1;
      req_ch.kind         <= kind;
      req_ch.proto        <= proto;
      req_ch.byte_count   <= bc;
      req_ch.seq_num      <= seq;
      req_ch.send_time    <= st;
      req_ch.recv_time    <= rt;
      req_ch.elapsed_time <= el;
      do @(posedge clock); while (!req_ch.ready);
      predict_stats(kind, proto, bc, seq, st, rt, el);
   endtask

   task automatic idle_cycles(int n);
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      idle_cycles(1);
      while (pending_stats.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] rand_elapsed();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return 64'd0;
      if (roll < 10) return 64'd1;
      if (roll < 15) return rand64();
      return 64'($urandom_range(1, 20000000));
   endfunction

   // rx word for a flow: mostly in order with near-real timestamps
   task automatic send_rx(logic [2:0] p);
      int roll;
      logic [63:0] st, rt;
      roll = $urandom_range(0, 99);
      if (roll < 70) gen_seq[p] = gen_seq[p] + 32'd1;
      else if (roll < 82) gen_seq[p] = gen_seq[p] + 32'($urandom_range(2, 40));
      else if (roll < 90) gen_seq[p] = gen_seq[p] - 32'($urandom_range(0, 5));
      else gen_seq[p] = $urandom;
      gen_time[p] = gen_time[p] + 64'($urandom_range(10, 5000));
      st = gen_time[p];
      rt = st + 64'($urandom_range(0, 3000));
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
         st = rand64();
         rt = rand64();
      end else if (roll < 10) begin
         rt = st - 64'($urandom_range(1, 500));
      end
      send_word(KIND_RX, p, 16'($urandom), gen_seq[p], st, rt, rand64());
   endtask

   task automatic test_records_directed();
      send_word(KIND_TX, 3'd0, 16'd0, 32'd0, 64'd0, 64'd0, 64'd0);
      send_word(KIND_TX, 3'd0, 16'hFFFF, MAX64[31:0], MAX64, MAX64, MAX64);
      send_word(KIND_RX, 3'd1, 16'hFFFF, 32'hFFFF_FFFF, 64'd100, 64'd150, 64'd0);
      // sequence wraps to zero: no loss
      send_word(KIND_RX, 3'd1, 16'd0, 32'd0, 64'd200, 64'd260, 64'd0);
      // forward gap and negative transit
      send_word(KIND_RX, 3'd1, 16'd64, 32'd10, 64'd500, 64'd400, 64'd0);
      send_word(KIND_RX, 3'd1, 16'd64, 32'd3, 64'd0, MAX64, 64'd0);
      send_word(KIND_RX, 3'd7, 16'd1, 32'd5, MAX64, 64'd0, 64'd0);
      send_word(KIND_RX, 3'd7, 16'd1, 32'd6, 64'd0, 64'h8000_0000_0000_0000, 64'd0);
   endtask

   task automatic test_reads_directed();
      send_word(KIND_READ_TOTAL, 3'd1, 16'd0, 32'd0, 64'd0, 64'd0, 64'd0);
      send_word(KIND_READ_TOTAL, 3'd0, 16'd0, 32'd0, 64'd0, 64'd0, 64'd1);
      send_word(KIND_READ_INTV, 3'd1, 16'd0, 32'd0, 64'd0, 64'd0, MAX64);
      // empty interval after the clear
      send_word(KIND_READ_INTV, 3'd1, 16'd0, 32'd0, 64'd0, 64'd0, 64'd1000000);
      send_word(KIND_READ_INTV, 3'd4, 16'd0, 32'd0, 64'd0, 64'd0, 64'd7);
      send_word(KIND_READ_TOTAL, 3'd7, 16'hFFFF, MAX64[31:0], MAX64, MAX64, 64'd3);
      send_word(KIND_CLEAR_ALL, 3'd2, 16'd0, 32'd0, 64'd0, 64'd0, 64'd0);
      send_word(KIND_READ_INTV, 3'd7, 16'd0, 32'd0, 64'd0, 64'd0, 64'd1);
      send_word(KIND_READ_TOTAL, 3'd7, 16'd0, 32'd0, 64'd0, 64'd0, 64'd2);
      wait_for_drain();
   endtask

   task automatic test_ignored_kinds();
      for (logic [3:0] k = {1'b0, KIND_UNUSED_MIN}; k <= {1'b0, KIND_UNUSED_MAX}; k++)
         send_word(k[2:0], 3'd1, 16'hFFFF, MAX64[31:0], MAX64, 64'd0, MAX64);
      send_word(KIND_READ_TOTAL, 3'd1, 16'd0, 32'd0, 64'd0, 64'd0, 64'd10);
      wait_for_drain();
   endtask

   // receiver holds off while reads and records keep coming
   task automatic test_backpressure();
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         begin
            for (int i = 0; i < 12; i++) begin
               send_word(KIND_TX, 3'(i), 16'($urandom), 32'd0, 64'd0, 64'd0, 64'd0);
               send_word((i % 2) ? KIND_READ_INTV : KIND_READ_TOTAL, 3'(i),
                         16'd0, 32'd0, 64'd0, 64'd0, rand_elapsed());
            end
            idle_cycles(1);
         end
      join
      wait_for_drain();
   endtask

   task automatic test_random_traffic();
      int sent, burst_left, roll;
      logic [2:0] p;
      sent = 0;
      burst_left = 0;
      while (sent < RANDOM_WORDS) begin
         // bursts with gaps in alternate stretches, back to back otherwise
         if (burst_left == 0) begin
            if ((sent / 200) % 2 == 1) idle_cycles($urandom_range(1, 25));
            burst_left = $urandom_range(1, 30);
         end
         burst_left--;
         p = 3'($urandom_range(0, NPROTO - 1));
         roll = $urandom_range(0, 99);
         if (roll < 42) begin
            send_rx(p);
         end else if (roll < 68) begin
            send_word(KIND_TX, p, 16'($urandom), $urandom, rand64(), rand64(), rand64());
         end else if (roll < 80) begin
            send_word(KIND_READ_INTV, p, 16'($urandom), $urandom, rand64(), rand64(),
                      rand_elapsed());
         end else if (roll < 92) begin
            send_word(KIND_READ_TOTAL, p, 16'($urandom), $urandom, rand64(), rand64(),
                      rand_elapsed());
         end else if (roll < 95) begin
            send_word(KIND_CLEAR_ALL, p, 16'($urandom), $urandom, rand64(), rand64(),
                      rand64());
         end else begin
            send_word(3'($urandom_range(KIND_UNUSED_MIN, KIND_UNUSED_MAX)), p,
                      16'($urandom), $urandom, rand64(), rand64(), rand64());
            sent--;
         end
         sent++;
      end
   endtask

   task automatic compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   // check each response word against the oldest prediction
   always @(posedge clock) begin : rsp_check
      stats_word_type w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_stats.size() == 0) begin
            $error("response word with no read outstanding");
            fail_count++;
         end else begin
            w = pending_stats.pop_front();
            compare_field("active", 64'(w.active), 64'(rsp_ch.active));
            compare_field("tx_count", w.tx_count, rsp_ch.tx_count);
            compare_field("rx_count", w.rx_count, rsp_ch.rx_count);
            compare_field("lost_count", w.lost_count, rsp_ch.lost_count);
            compare_field("loss_hundredths", 64'(w.loss_hundredths),
                          64'(rsp_ch.loss_hundredths));
            compare_field("packets_per_sec", w.packets_per_sec, rsp_ch.packets_per_sec);
            compare_field("bytes_per_sec", w.bytes_per_sec, rsp_ch.bytes_per_sec);
            compare_field("latency_avg", w.latency_avg, rsp_ch.latency_avg);
            compare_field("latency_min", w.latency_min, rsp_ch.latency_min);
            compare_field("latency_max", w.latency_max, rsp_ch.latency_max);
            compare_field("jitter", w.jitter, rsp_ch.jitter);
         end
      end
   end

   initial begin
      fail_count  = 0;
      cycle_count = 0;
      hold_rsp    = 1'b0;
      for (int p = 0; p < NPROTO; p++) begin
         gen_seq[p]  = $urandom;
         gen_time[p] = 64'($urandom);
      end
      clear_predictor();
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.kind         = KIND_TX;
      req_ch.proto        = 3'd0;
      req_ch.byte_count   = 16'd0;
      req_ch.seq_num      = 32'd0;
      req_ch.send_time    = 64'd0;
      req_ch.recv_time    = 64'd0;
      req_ch.elapsed_time = 64'd0;
      rsp_ch.ready        = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_records_directed();
      test_reads_directed();
      test_ignored_kinds();
      test_backpressure();
      test_random_traffic();

      // drain and let the block settle
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_stats.size() == 0)
         $display("per_flow_traffic_stats_unit regression: pass");
      else
         $display("per_flow_traffic_stats_unit regression: fail");
      $finish;
   end

endmodule
